// File: hdl/tci_pkg.sv
// Package for the terminal control interpreter.
// Holds command codes, character codes, screen defaults and the internal operation type.
// Depends on nothing.
package tci_pkg;

  localparam int ROWS_DEF = 10;
  localparam int COLS_DEF = 10;
  localparam int CHAR_W = 8;

  localparam logic [1:0] CMD_FEED = 2'd0;
  localparam logic [1:0] CMD_NEW = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_ERASE,
    OP_READ
  } op_t;

endpackage

// File: hdl/tci_ram.sv
// Generic single-write, single-read RAM with a registered read port and read enable.
// Depends on nothing.
module tci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/terminal_control_interpreter_core.sv
// Terminal control interpreter: a new input beat can be accepted every clock cycle unless
// a read waits in the row stage while the output register holds an unaccepted result.
// Commands and control bytes update the cursor and mode at once; screen rows live in a
// row-wide RAM, each read, put or erase reads a single row, and a put or erase writes
// it back modified. A read result passes from the row stage into the output register
// once that register is free. No clearing pass is needed.
// Depends on tci_pkg and tci_ram.
module terminal_control_interpreter_core #(
  parameter int ROWS = tci_pkg::ROWS_DEF,
  parameter int COLS = tci_pkg::COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  input  logic [3:0] read_row,
  input  logic [3:0] read_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_char,
  output logic [3:0] cursor_row_now,
  output logic [3:0] cursor_col_now,
  output logic       insert_active
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int CHW = tci_pkg::CHAR_W;
  localparam logic [3:0] ROWS_4 = 4'(ROWS);
  localparam logic [3:0] COLS_4 = 4'(COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_CARET,
    ESC_ROW
  } esc_t;

  typedef logic [COLS-1:0][CHW-1:0] row_t;

  esc_t            esc, esc_next;
  logic [RW-1:0]   cursor_row, cursor_row_next;
  logic [CW-1:0]   cursor_col, cursor_col_next;
  logic [RW-1:0]   pending_row, pending_row_next;
  logic            insert_mode, insert_mode_next;
  logic [ROWS-1:0] row_valid;

  logic            s1_valid;
  tci_pkg::op_t    s1_op;
  logic [RW-1:0]   s1_row;
  logic [CW-1:0]   s1_col;
  logic [CHW-1:0]  s1_ch;
  logic            s1_ins;
  logic            s1_inrange;
  logic            s1_rvalid;
  logic [RW-1:0]   s1_cur_row;
  logic [CW-1:0]   s1_cur_col;
  logic            s1_insert;

  logic            byp_valid;
  logic [RW-1:0]   byp_row;
  row_t            byp_data;

  logic            acc;
  logic            clear_now;
  logic            digit;
  logic [3:0]      dval;
  logic [RW-1:0]   dig_row;
  logic [CW-1:0]   dig_col;
  tci_pkg::op_t    op;
  logic [CHW-1:0]  put_ch;
  logic [RW-1:0]   rd_addr;
  logic            inrange;

  row_t            ram_q;
  row_t            row_old;
  row_t            row_sh;
  row_t            row_new;
  logic            s1_adv;
  logic            wr_en;
  logic [CHW-1:0]  cell_sel;

  assign acc = in_valid && in_ready;
  assign digit = (data_byte >= tci_pkg::CH_ZERO) && (data_byte <= tci_pkg::CH_NINE);
  assign dval = 4'(data_byte - tci_pkg::CH_ZERO);
  assign dig_row = (dval < ROWS_4) ? dval[RW-1:0] : LAST_ROW;
  assign dig_col = (dval < COLS_4) ? dval[CW-1:0] : LAST_COL;
  assign inrange = (read_row < ROWS_4) && (read_col < COLS_4);

  always_comb begin
    esc_next = esc;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    pending_row_next = pending_row;
    insert_mode_next = insert_mode;
    clear_now = 1'b0;
    op = tci_pkg::OP_NONE;
    put_ch = data_byte;
    case (command)
      tci_pkg::CMD_FEED: begin
        case (esc)
          ESC_IDLE: begin
            if (data_byte == tci_pkg::CH_CARET) begin
              esc_next = ESC_CARET;
            end else begin
              op = tci_pkg::OP_PUT;
            end
          end
          ESC_CARET: begin
            if (digit) begin
              pending_row_next = dig_row;
              esc_next = ESC_ROW;
            end else begin
              esc_next = ESC_IDLE;
              case (data_byte)
                tci_pkg::CH_B: cursor_col_next = '0;
                tci_pkg::CH_C: clear_now = 1'b1;
                tci_pkg::CH_D: begin
                  if (cursor_row != LAST_ROW) begin
                    cursor_row_next = cursor_row + 1'b1;
                  end
                end
                tci_pkg::CH_E: op = tci_pkg::OP_ERASE;
                tci_pkg::CH_H: begin
                  cursor_row_next = '0;
                  cursor_col_next = '0;
                end
                tci_pkg::CH_I: insert_mode_next = 1'b1;
                tci_pkg::CH_L: begin
                  if (cursor_col != '0) begin
                    cursor_col_next = cursor_col - 1'b1;
                  end
                end
                tci_pkg::CH_O: insert_mode_next = 1'b0;
                tci_pkg::CH_R: begin
                  if (cursor_col != LAST_COL) begin
                    cursor_col_next = cursor_col + 1'b1;
                  end
                end
                tci_pkg::CH_U: begin
                  if (cursor_row != '0) begin
                    cursor_row_next = cursor_row - 1'b1;
                  end
                end
                tci_pkg::CH_CARET: op = tci_pkg::OP_PUT;
                default: ;
              endcase
            end
          end
          ESC_ROW: begin
            cursor_row_next = pending_row;
            if (digit) begin
              cursor_col_next = dig_col;
            end
            esc_next = ESC_IDLE;
          end
          default: esc_next = ESC_IDLE;
        endcase
        if (op == tci_pkg::OP_PUT && cursor_col != LAST_COL) begin
          cursor_col_next = cursor_col + 1'b1;
        end
      end
      tci_pkg::CMD_NEW: begin
        clear_now = 1'b1;
        cursor_row_next = '0;
        cursor_col_next = '0;
        insert_mode_next = 1'b0;
        esc_next = ESC_IDLE;
        pending_row_next = '0;
      end
      tci_pkg::CMD_READ: op = tci_pkg::OP_READ;
      default: ;
    endcase
  end

  assign rd_addr = (op == tci_pkg::OP_READ) ? read_row[RW-1:0] : cursor_row;

  tci_ram #(
    .WIDTH(COLS * CHW),
    .DEPTH(ROWS)
  ) u_rows (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_row),
    .wdata(row_new),
    .re   (acc),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_comb begin
    if (byp_valid && byp_row == s1_row) begin
      row_old = byp_data;
    end else if (s1_rvalid) begin
      row_old = ram_q;
    end else begin
      row_old = {COLS{tci_pkg::CH_SPACE}};
    end
  end

  assign row_sh = {row_old[COLS-2:0], tci_pkg::CH_SPACE};

  always_comb begin
    row_new = row_old;
    for (int i = 0; i < COLS; i++) begin
      case (s1_op)
        tci_pkg::OP_PUT: begin
          if (CW'(i) == s1_col) begin
            row_new[i] = s1_ch;
          end else if (s1_ins && CW'(i) > s1_col) begin
            row_new[i] = row_sh[i];
          end
        end
        tci_pkg::OP_ERASE: begin
          if (CW'(i) >= s1_col) begin
            row_new[i] = tci_pkg::CH_SPACE;
          end
        end
        default: ;
      endcase
    end
  end

  assign cell_sel = s1_inrange ? row_old[s1_col] : '0;
  assign s1_adv = s1_valid && (s1_op != tci_pkg::OP_READ || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign wr_en = s1_adv && (s1_op == tci_pkg::OP_PUT || s1_op == tci_pkg::OP_ERASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= ESC_IDLE;
      cursor_row <= '0;
      cursor_col <= '0;
      pending_row <= '0;
      insert_mode <= 1'b0;
      row_valid <= '0;
      s1_valid <= 1'b0;
      byp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        esc <= esc_next;
        cursor_row <= cursor_row_next;
        cursor_col <= cursor_col_next;
        pending_row <= pending_row_next;
        insert_mode <= insert_mode_next;
        s1_op <= op;
        s1_row <= rd_addr;
        s1_col <= (op == tci_pkg::OP_READ) ? read_col[CW-1:0] : cursor_col;
        s1_ch <= put_ch;
        s1_ins <= insert_mode;
        s1_inrange <= inrange;
        s1_rvalid <= row_valid[rd_addr];
        s1_cur_row <= cursor_row;
        s1_cur_col <= cursor_col;
        s1_insert <= insert_mode;
        byp_valid <= wr_en && !clear_now;
        byp_row <= s1_row;
        byp_data <= row_new;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (acc && clear_now) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[s1_row] <= 1'b1;
      end
      if (s1_adv && s1_op == tci_pkg::OP_READ) begin
        out_valid <= 1'b1;
        cell_char <= cell_sel;
        cursor_row_now <= 4'(s1_cur_row);
        cursor_col_now <= 4'(s1_cur_col);
        insert_active <= s1_insert;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    cursor_row <= LAST_ROW && cursor_col <= LAST_COL)
    else $error("cursor outside the screen");

  a_pending_in_screen: assert property (@(posedge clk) disable iff (rst)
    esc == ESC_ROW |-> pending_row <= LAST_ROW)
    else $error("pending row outside the screen");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !in_ready)
    else $error("input taken while the row stage is stalled");

  a_write_needs_stage: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && s1_op != tci_pkg::OP_READ)
    else $error("row write without a pending put or erase");

  a_clear_drops_rows: assert property (@(posedge clk) disable iff (rst)
    acc && clear_now |=> row_valid == '0 && !byp_valid)
    else $error("screen clear left a valid row");
`endif

endmodule

// File: tb/tci_tb_pkg.sv
// Scoreboard for the terminal control interpreter testbench: a shadow of the screen,
// cursor, mode and control-sequence state, and the queue of expected cell readouts.
// Depends on tci_pkg.
package tci_tb_pkg;

  import tci_pkg::*;

  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int SCREEN_COLS = COLS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CARET,
    SEQ_ROW_DIGIT
  } seq_phase_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [3:0] row;
    logic [3:0] col;
    logic       ins;
  } readout_t;

  class terminal_scoreboard;
    logic [7:0] screen [SCREEN_ROWS][SCREEN_COLS];
    logic [3:0] cur_row;
    logic [3:0] cur_col;
    logic       insert_on;
    seq_phase_t phase;
    logic [3:0] pending_row;
    readout_t   expected_readouts[$];
    int         failures;
    int         bytes_fed;
    int         screens_started;
    int         readouts_checked;
    int         insert_readouts;

    function new();
      start_screen();
      failures = 0;
      bytes_fed = 0;
      screens_started = 0;
      readouts_checked = 0;
      insert_readouts = 0;
    endfunction

    function void blank_screen();
      foreach (screen[r, c]) screen[r][c] = CH_SPACE;
    endfunction

    function void start_screen();
      blank_screen();
      cur_row = '0;
      cur_col = '0;
      insert_on = 1'b0;
      phase = SEQ_IDLE;
      pending_row = '0;
    endfunction

    function logic [3:0] clamp_to(int v, int lim);
      return (v < lim) ? 4'(v) : 4'(lim - 1);
    endfunction

    function void put_char(logic [7:0] ch);
      if (insert_on) begin
        for (int i = SCREEN_COLS - 1; i > int'(cur_col); i--)
          screen[cur_row][i] = screen[cur_row][i - 1];
      end
      screen[cur_row][cur_col] = ch;
      if (cur_col < SCREEN_COLS - 1) cur_col++;
    endfunction

    function void control_letter(logic [7:0] ch);
      case (ch)
        CH_B: cur_col = '0;
        CH_C: blank_screen();
        CH_D: if (cur_row < SCREEN_ROWS - 1) cur_row++;
        CH_E: for (int i = int'(cur_col); i < SCREEN_COLS; i++) screen[cur_row][i] = CH_SPACE;
        CH_H: begin
          cur_row = '0;
          cur_col = '0;
        end
        CH_I: insert_on = 1'b1;
        CH_L: if (cur_col > 0) cur_col--;
        CH_O: insert_on = 1'b0;
        CH_R: if (cur_col < SCREEN_COLS - 1) cur_col++;
        CH_U: if (cur_row > 0) cur_row--;
        CH_CARET: put_char(CH_CARET);
        default: ;
      endcase
    endfunction

    function void feed_byte(logic [7:0] ch);
      bit is_digit;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      case (phase)
        SEQ_CARET: begin
          if (is_digit) begin
            pending_row = clamp_to(int'(ch) - int'(CH_ZERO), SCREEN_ROWS);
            phase = SEQ_ROW_DIGIT;
          end else begin
            phase = SEQ_IDLE;
            control_letter(ch);
          end
        end
        SEQ_ROW_DIGIT: begin
          cur_row = clamp_to(int'(pending_row), SCREEN_ROWS);
          if (is_digit) cur_col = clamp_to(int'(ch) - int'(CH_ZERO), SCREEN_COLS);
          phase = SEQ_IDLE;
        end
        default: begin
          if (ch == CH_CARET) phase = SEQ_CARET;
          else put_char(ch);
        end
      endcase
    endfunction

    function void note_beat(logic [1:0] cmd, logic [7:0] ch, logic [3:0] row, logic [3:0] col);
      readout_t r;
      case (cmd)
        CMD_FEED: begin
          feed_byte(ch);
          bytes_fed++;
        end
        CMD_NEW: begin
          start_screen();
          screens_started++;
        end
        CMD_READ: begin
          r.glyph = (row < SCREEN_ROWS && col < SCREEN_COLS) ? screen[row][col] : 8'h00;
          r.row = cur_row;
          r.col = cur_col;
          r.ins = insert_on;
          expected_readouts.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_readout(logic [7:0] glyph, logic [3:0] row, logic [3:0] col,
                                logic ins);
      readout_t got;
      readout_t exp;
      got = '{glyph, row, col, ins};
      if (expected_readouts.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected readout: cell %02h row %0d col %0d ins %0b",
                   glyph, row, col, ins);
      end else begin
        exp = expected_readouts.pop_front();
        readouts_checked++;
        if (exp.ins) insert_readouts++;
        if (got !== exp) begin
          failures++;
          if (failures <= 10)
            $display({"Readout mismatch: expected cell %02h row %0d col %0d ins %0b, ",
                      "got cell %02h row %0d col %0d ins %0b"},
                     exp.glyph, exp.row, exp.col, exp.ins, glyph, row, col, ins);
        end
      end
    endfunction

    function int pending_count();
      return expected_readouts.size();
    endfunction

    function void close_out();
      if (expected_readouts.size() != 0) begin
        $display("%0d expected readouts never arrived", expected_readouts.size());
        failures += expected_readouts.size();
      end
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
// Top-level testbench for terminal_control_interpreter_core: directed and random byte
// streams with reads, random bursts and stalls on both channels, checked by the scoreboard.
// Depends on tci_pkg, tci_tb_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tci_pkg::*;
  import tci_tb_pkg::*;

  localparam int RANDOM_BEATS = 1850;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [3:0] read_row;
  logic [3:0] read_col;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] cell_char;
  logic [3:0] cursor_row_now;
  logic [3:0] cursor_col_now;
  logic       insert_active;

  terminal_scoreboard sb = new();

  int burst_left;
  int beats_sent;
  int idle_cycles;
  bit interleave_reads;
  bit hold_off_request;
  bit hold_off_done;
  bit drain_done;

  terminal_control_interpreter_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .data_byte(data_byte),
    .read_row(read_row),
    .read_col(read_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_char(cell_char),
    .cursor_row_now(cursor_row_now),
    .cursor_col_now(cursor_col_now),
    .insert_active(insert_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_beat(command, data_byte, read_row, read_col);
      if (out_valid && out_ready)
        sb.check_readout(cell_char, cursor_row_now, cursor_col_now, insert_active);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    int tick;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_request && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = (tick % 4 == 0);
          default: out_ready = ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch,
                           input logic [3:0] row, input logic [3:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    data_byte = ch;
    read_row = row;
    read_col = col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != CMD_UNUSED) beats_sent++;
  endtask

  task automatic feed(input logic [7:0] ch);
    send_beat(CMD_FEED, ch, 4'($urandom), 4'($urandom));
  endtask

  task automatic read_cell(input logic [3:0] row, input logic [3:0] col);
    send_beat(CMD_READ, 8'($urandom), row, col);
  endtask

  task automatic random_read();
    if ($urandom_range(0, 7) == 0) read_cell(4'($urandom), 4'($urandom));
    else read_cell(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
  endtask

  task automatic maybe_read();
    if (interleave_reads && $urandom_range(0, 9) == 0) random_read();
  endtask

  task automatic escape(input logic [7:0] ch);
    feed(CH_CARET);
    maybe_read();
    feed(ch);
  endtask

  task automatic random_sequence();
    logic [7:0] letters [10];
    logic [7:0] letter;
    int pick;
    letters = '{CH_B, CH_C, CH_D, CH_E, CH_H, CH_I, CH_L, CH_O, CH_R, CH_U};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      random_read();
    end else if (pick < 55) begin
      if ($urandom_range(0, 3) == 0) feed(8'($urandom));
      else feed(8'($urandom_range(8'h21, 8'h7e)));
    end else if (pick < 70) begin
      letter = letters[$urandom_range(0, 9)];
      if (letter == CH_C && $urandom_range(0, 3) != 0) letter = CH_R;
      escape(letter);
    end else if (pick < 80) begin
      escape(CH_ZERO + 8'($urandom_range(0, 9)));
      maybe_read();
      if ($urandom_range(0, 4) != 0) feed(CH_ZERO + 8'($urandom_range(0, 9)));
      else feed(8'($urandom));
    end else if (pick < 84) begin
      escape(CH_CARET);
    end else if (pick < 89) begin
      escape(8'($urandom));
    end else if (pick < 97) begin
      feed(8'($urandom));
    end else if (pick < 98) begin
      send_beat(CMD_NEW, 8'($urandom), 4'($urandom), 4'($urandom));
    end else begin
      send_beat(CMD_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_FEED;
    data_byte = '0;
    read_row = '0;
    read_col = '0;
    burst_left = 0;
    beats_sent = 0;
    interleave_reads = 1'b0;
    hold_off_request = 1'b0;
    hold_off_done = 1'b0;
    drain_done = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    read_cell(4'd0, 4'd0);
    feed(8'h41);
    feed(8'hff);
    escape(CH_I);
    feed(8'h00);
    escape(CH_B);
    feed(8'h5a);
    read_cell(4'd0, 4'd1);
    feed(CH_CARET);
    feed(CH_ZERO + 8'd9);
    feed(CH_ZERO + 8'd9);
    feed(8'h51);
    escape(CH_D);
    escape(CH_R);
    read_cell(4'd9, 4'd9);
    feed(CH_CARET);
    feed(CH_ZERO + 8'd5);
    feed(8'h78);
    escape(CH_L);
    escape(CH_U);
    escape(CH_E);
    escape(CH_CARET);
    escape(8'h7a);
    escape(CH_O);
    escape(CH_H);
    read_cell(4'd4, 4'd8);
    escape(CH_C);
    send_beat(CMD_UNUSED, 8'hff, 4'hf, 4'hf);
    send_beat(CMD_NEW, 8'h00, 4'h0, 4'h0);
    read_cell(4'hf, 4'hf);

    interleave_reads = 1'b1;
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= 500) hold_off_request = 1'b1;
      if (beats_sent >= 1200 && !drain_done) begin
        drain_done = 1'b1;
        random_read();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
      end
      random_sequence();
    end

    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    $display("Fed %0d bytes, started %0d new screens, checked %0d cell readouts",
             sb.bytes_fed, sb.screens_started, sb.readouts_checked);
    $display("(%0d in insert mode) under bursty input and stalled output.",
             sb.insert_readouts);
    if (sb.failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tci_pkg.sv
hdl/tci_ram.sv
hdl/terminal_control_interpreter_core.sv
tb/tci_tb_pkg.sv
tb/testbench.sv
